[hw/rtl/nhr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nhr_pkg
// Types and codes shared by the next-hop resolver modules.
// ----------------------------------------------------------------------------
package nhr_pkg;

    localparam logic [2:0] FUNC_CLEAR     = 3'd0;
    localparam logic [2:0] FUNC_ADD_ROUTE = 3'd1;
    localparam logic [2:0] FUNC_ADD_ARP   = 3'd2;
    localparam logic [2:0] FUNC_ADD_DEV   = 3'd3;
    localparam logic [2:0] FUNC_LOOKUP    = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_ROUTE = 3'd1;
    localparam logic [2:0] ST_NO_ARP   = 3'd2;
    localparam logic [2:0] ST_NO_DEV   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] addr_a;
        logic [31:0] netmask;
        logic [31:0] gateway;
        logic        is_default;
        logic        is_direct;
        logic [3:0]  iface;
        logic [47:0] mac;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  out_iface;
        logic [47:0] next_hop_mac;
        logic [31:0] hop_addr;
        logic [31:0] local_addr;
    } rsp_t;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_LATCH,
        CMD_RT_SCAN,
        CMD_ARP_SCAN,
        CMD_DEV_SCAN
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    scan_start;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic hit;
    } sts_t;

endpackage
`default_nettype wire

[hw/rtl/nhr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nhr_ctrl
// Sequencer: request handshake, scan ordering and result status.
// ----------------------------------------------------------------------------
module nhr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic [2:0]    req_func,
    input  wire logic          full_route,
    input  wire logic          full_arp,
    input  wire logic          full_dev,
    input  wire nhr_pkg::sts_t sts,
    output nhr_pkg::cmd_t      cmd,
    output logic               req_stall,
    output logic               rsp_load,
    output logic [2:0]         rsp_status,
    output logic [2:0]         rsp_keep,
    output logic               rsp_valid,
    input  wire logic          rsp_stall
);
    import nhr_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_RT, S_ARP, S_DEV, S_OUT} state_t;

    state_t     state_reg, state_next;
    logic       rv_reg, rv_next;
    logic [2:0] st_reg, st_next;
    logic       first_reg, first_next;

    logic accept;
    assign req_stall = (state_reg != S_IDLE) || rv_reg;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rv_reg;
    assign rsp_status = st_next;

    always_comb
    begin
        state_next = state_reg;
        rv_next    = rv_reg && rsp_stall;
        st_next    = st_reg;
        first_next = 1'b0;
        cmd.op     = CMD_IDLE;
        cmd.scan_start = first_reg;
        rsp_load   = 1'b0;
        rsp_keep   = 3'b000;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op   = CMD_LATCH;
                    rsp_load = 1'b1;
                    st_next  = ST_OK;
                    unique case (req_func)
                        FUNC_ADD_ROUTE: if (full_route) st_next = ST_FULL;
                        FUNC_ADD_ARP:   if (full_arp)   st_next = ST_FULL;
                        FUNC_ADD_DEV:   if (full_dev)   st_next = ST_FULL;
                        default: ;
                    endcase
                    if (req_func == FUNC_LOOKUP)
                    begin
                        state_next = S_RT;
                        first_next = 1'b1;
                    end
                    else
                        rv_next = 1'b1;
                end
            end
            S_RT:
            begin
                cmd.op = CMD_RT_SCAN;
                if (sts.scan_done)
                begin
                    if (sts.hit)
                    begin
                        state_next = S_ARP;
                        first_next = 1'b1;
                    end
                    else
                    begin
                        st_next    = ST_NO_ROUTE;
                        state_next = S_OUT;
                    end
                end
            end
            S_ARP:
            begin
                cmd.op   = CMD_ARP_SCAN;
                rsp_keep = 3'b011;
                if (sts.scan_done)
                begin
                    if (sts.hit)
                    begin
                        state_next = S_DEV;
                        first_next = 1'b1;
                    end
                    else
                    begin
                        st_next    = ST_NO_ARP;
                        state_next = S_OUT;
                    end
                end
            end
            S_DEV:
            begin
                cmd.op   = CMD_DEV_SCAN;
                rsp_keep = 3'b111;
                if (sts.scan_done)
                begin
                    st_next    = sts.hit ? ST_OK : ST_NO_DEV;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                rv_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
            st_reg    <= ST_OK;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            st_reg    <= st_next;
            first_reg <= first_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> req_stall) else $error("accept while busy");
    a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |=> rv_reg) else $error("lookup result lost");
    a_no_scan_while_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> state_reg == S_IDLE) else $error("scan with pending result");
`endif
endmodule
`default_nettype wire

[hw/rtl/nhr_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nhr_datapath
// Route, ARP and interface tables with a one-entry-per-cycle scanner.
// ----------------------------------------------------------------------------
module nhr_datapath #(
    parameter int ROUTE_DEPTH = 16,
    parameter int ARP_DEPTH   = 16,
    parameter int DEV_DEPTH   = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire nhr_pkg::req_t req,
    input  wire nhr_pkg::cmd_t cmd,
    input  wire logic          rsp_load,
    input  wire logic [2:0]    rsp_keep,
    input  wire logic [2:0]    rsp_status,
    output nhr_pkg::sts_t      sts,
    output logic               full_route,
    output logic               full_arp,
    output logic               full_dev,
    output nhr_pkg::rsp_t      rsp
);
    import nhr_pkg::*;

    localparam int RW = $clog2(ROUTE_DEPTH + 1);
    localparam int AW = $clog2(ARP_DEPTH + 1);
    localparam int DW = $clog2(DEV_DEPTH + 1);
    localparam int RI = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
    localparam int AI = (ARP_DEPTH > 1) ? $clog2(ARP_DEPTH) : 1;
    localparam int DI = (DEV_DEPTH > 1) ? $clog2(DEV_DEPTH) : 1;
    localparam int SW = (RW > AW) ? ((RW > DW) ? RW : DW) : ((AW > DW) ? AW : DW);

    logic [31:0] rt_dest [ROUTE_DEPTH];
    logic [31:0] rt_mask [ROUTE_DEPTH];
    logic [31:0] rt_gw   [ROUTE_DEPTH];
    logic [1:0]  rt_flag [ROUTE_DEPTH];
    logic [3:0]  rt_port [ROUTE_DEPTH];
    logic [31:0] arp_ip  [ARP_DEPTH];
    logic [47:0] arp_mac [ARP_DEPTH];
    logic [3:0]  dev_port[DEV_DEPTH];
    logic [31:0] dev_addr[DEV_DEPTH];

    logic [RW-1:0] rcnt_reg;
    logic [AW-1:0] acnt_reg;
    logic [DW-1:0] dcnt_reg;
    logic [SW-1:0] idx_reg, idx_next;
    logic          hdef_reg, hdef_next;
    logic [RI-1:0] def_reg, def_next;

    logic [31:0] dst_reg;
    rsp_t        rsp_reg;

    logic [SW-1:0] idx;
    logic [SW-1:0] lim;
    logic          at_end;
    logic [RI-1:0] ri;
    logic [AI-1:0] ai;
    logic [DI-1:0] di;
    logic [RI-1:0] sel;
    logic          rhit;
    logic [31:0]   nh;

    assign full_route = rcnt_reg == RW'(ROUTE_DEPTH);
    assign full_arp   = acnt_reg == AW'(ARP_DEPTH);
    assign full_dev   = dcnt_reg == DW'(DEV_DEPTH);
    assign rsp        = rsp_reg;

    assign idx = cmd.scan_start ? '0 : idx_reg;
    assign ri  = RI'(idx);
    assign ai  = AI'(idx);
    assign di  = DI'(idx);

    always_comb
    begin
        case (cmd.op)
            CMD_RT_SCAN:  lim = SW'(rcnt_reg);
            CMD_ARP_SCAN: lim = SW'(acnt_reg);
            default:      lim = SW'(dcnt_reg);
        endcase
    end
    assign at_end = idx >= lim;

    assign rhit = !rt_flag[ri][0] && ((rt_mask[ri] & dst_reg) == rt_dest[ri]);
    assign sel  = (at_end) ? def_reg : ri;
    assign nh   = rt_flag[sel][1] ? dst_reg : rt_gw[sel];

    always_comb
    begin
        idx_next  = idx + SW'(1);
        hdef_next = cmd.scan_start ? 1'b0 : hdef_reg;
        def_next  = def_reg;
        sts.scan_done = 1'b0;
        sts.hit       = 1'b0;
        case (cmd.op)
            CMD_RT_SCAN:
            begin
                if (at_end)
                begin
                    sts.scan_done = 1'b1;
                    sts.hit       = hdef_next;
                end
                else if (rt_flag[ri][0])
                begin
                    hdef_next = 1'b1;
                    def_next  = ri;
                end
                else if (rhit)
                begin
                    sts.scan_done = 1'b1;
                    sts.hit       = 1'b1;
                end
            end
            CMD_ARP_SCAN:
            begin
                sts.scan_done = at_end || (arp_ip[ai] == rsp_reg.hop_addr);
                sts.hit       = !at_end;
            end
            CMD_DEV_SCAN:
            begin
                sts.scan_done = at_end || (dev_port[di] == rsp_reg.out_iface);
                sts.hit       = !at_end;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_LATCH)
        begin
            dst_reg <= req.addr_a;
            if (req.func == FUNC_ADD_ROUTE && !full_route)
            begin
                rt_dest[RI'(rcnt_reg)] <= req.addr_a;
                rt_mask[RI'(rcnt_reg)] <= req.netmask;
                rt_gw[RI'(rcnt_reg)]   <= req.gateway;
                rt_flag[RI'(rcnt_reg)] <= {req.is_direct, req.is_default};
                rt_port[RI'(rcnt_reg)] <= req.iface;
            end
            if (req.func == FUNC_ADD_ARP && !full_arp)
            begin
                arp_ip[AI'(acnt_reg)]  <= req.addr_a;
                arp_mac[AI'(acnt_reg)] <= req.mac;
            end
            if (req.func == FUNC_ADD_DEV && !full_dev)
            begin
                dev_port[DI'(dcnt_reg)] <= req.iface;
                dev_addr[DI'(dcnt_reg)] <= req.addr_a;
            end
        end
        if (rsp_load)
        begin
            rsp_reg.status       <= rsp_status;
            rsp_reg.out_iface    <= '0;
            rsp_reg.next_hop_mac <= '0;
            rsp_reg.hop_addr     <= '0;
            rsp_reg.local_addr   <= '0;
        end
        else
        begin
            rsp_reg.status <= rsp_status;
            if (cmd.op == CMD_RT_SCAN && sts.scan_done)
            begin
                if (sts.hit)
                begin
                    rsp_reg.out_iface <= rt_port[sel];
                    rsp_reg.hop_addr  <= nh;
                end
            end
            if (cmd.op == CMD_ARP_SCAN && sts.scan_done && sts.hit)
                rsp_reg.next_hop_mac <= arp_mac[ai];
            if (cmd.op == CMD_DEV_SCAN && sts.scan_done && sts.hit)
                rsp_reg.local_addr <= dev_addr[di];
            if (!rsp_keep[0] && cmd.op == CMD_IDLE && rsp_status == ST_NO_ROUTE)
            begin
                rsp_reg.out_iface <= '0;
                rsp_reg.hop_addr  <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcnt_reg <= '0;
            acnt_reg <= '0;
            dcnt_reg <= '0;
            idx_reg  <= '0;
            hdef_reg <= 1'b0;
            def_reg  <= '0;
        end
        else
        begin
            idx_reg  <= idx_next;
            hdef_reg <= hdef_next;
            def_reg  <= def_next;
            if (cmd.op == CMD_LATCH)
            begin
                case (req.func)
                    FUNC_CLEAR:
                    begin
                        rcnt_reg <= '0;
                        acnt_reg <= '0;
                        dcnt_reg <= '0;
                    end
                    FUNC_ADD_ROUTE: if (!full_route) rcnt_reg <= rcnt_reg + RW'(1);
                    FUNC_ADD_ARP:   if (!full_arp)   acnt_reg <= acnt_reg + AW'(1);
                    FUNC_ADD_DEV:   if (!full_dev)   dcnt_reg <= dcnt_reg + DW'(1);
                    default: ;
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_rcnt: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg <= RW'(ROUTE_DEPTH)) else $error("route count overflow");
    a_acnt: assert property (@(posedge clk) disable iff (!rst_n)
        acnt_reg <= AW'(ARP_DEPTH)) else $error("arp count overflow");
    a_dcnt: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= DW'(DEV_DEPTH)) else $error("interface count overflow");
`endif
endmodule
`default_nettype wire

[hw/rtl/next_hop_resolver.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// next_hop_resolver
// Route, ARP and interface tables with next-hop lookup.
// ----------------------------------------------------------------------------
// Usage: requests enter on req (req_valid/req_stall) and each gives one
// response on rsp (rsp_valid/rsp_stall). Clear, append and unused requests
// answer in the cycle after acceptance. A lookup scans the route table, then
// the ARP table, then the interface table, one entry per cycle, and stops at
// the first table that misses; a hit ends a scan early. One request is
// worked at a time; the next is taken in the cycle after the previous
// response has been taken. Reset empties all tables. While rsp_stall is
// high the response holds and req stays stalled.
// ----------------------------------------------------------------------------
module next_hop_resolver #(
    parameter int ROUTE_DEPTH = 16,
    parameter int ARP_DEPTH   = 16,
    parameter int DEV_DEPTH   = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire nhr_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output nhr_pkg::rsp_t      rsp
);
    import nhr_pkg::*;

    cmd_t       cmd;
    sts_t       sts;
    logic       full_route, full_arp, full_dev, rsp_load;
    logic [2:0] rsp_keep, rsp_status;

    nhr_ctrl u_ctrl (
        .clk, .rst_n, .req_valid, .req_func(req.func),
        .full_route, .full_arp, .full_dev, .sts, .cmd, .req_stall,
        .rsp_load, .rsp_status, .rsp_keep, .rsp_valid, .rsp_stall
    );

    nhr_datapath #(
        .ROUTE_DEPTH(ROUTE_DEPTH), .ARP_DEPTH(ARP_DEPTH), .DEV_DEPTH(DEV_DEPTH)
    ) u_dp (
        .clk, .rst_n, .req, .cmd, .rsp_load, .rsp_keep, .rsp_status, .sts,
        .full_route, .full_arp, .full_dev, .rsp
    );
endmodule
`default_nettype wire
